[src/dcls_pkg.sv]
// ----------------------------------------------------------------------------
// dcls_pkg: shared types and constants for the daisy-chain LED serializer
// Beat structs for both channels, the classified job handed from front to
// back, and sizing constants.
// ----------------------------------------------------------------------------
package dcls_pkg;

   localparam int DCLS_MAX_DEVICES = 4;
   localparam int FRAME_BITS       = 16;
   localparam int BIT_IDX_W        = $clog2(FRAME_BITS);
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [2:0]  CSR_LENGTH_RESET = 3'd4;
   localparam logic [15:0] NOOP_FRAME       = 16'h0000;

   localparam logic KIND_BROADCAST = 1'b0;
   localparam logic KIND_TARGETED  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [2:0] target_device;
      logic [7:0] register_address;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic serial_bit;
      logic last_bit;
   } rsp_type;

   // Classified write: frame, mode, clamped target and clamped chain length
   typedef struct packed {
      logic [FRAME_BITS-1:0] frame;
      logic                  kind;
      logic [2:0]            target;
      logic [2:0]            length;
   } job_type;

endpackage

[src/daisy_chain_led_driver_serializer.sv]
// ----------------------------------------------------------------------------
// daisy_chain_led_driver_serializer: register write serializer for a chain
// of daisy-chained LED driver chips
// Usage:
//   req_ channel: one beat per register write (kind, target_device,
//     register_address, data_byte). Accepted when req_valid && !req_stall.
//   rsp_ channel: one beat per serial bit (serial_bit, last_bit), farthest
//     chip first, address byte then data byte, MSB first. last_bit marks the
//     final bit of a write; raise the load strobe after it.
//   csr_ port: csr_write_enable / csr_write_data set chain_length (reset 4);
//     write only while idle.
// The first bit passes through the job queue, the job register and the output
// register. The serializer shifts one bit per cycle while no stalled beat is
//   held, 16 bits per chip; queued writes follow each other without gaps.
// A two-entry job queue lets requests be taken while a write is shifting.
// Reset clears the queue, the serializer and the output valid flag, and sets
//   chain_length to 4. While rsp_stall is high the current bit holds and the
//   serializer waits; req_stall rises once the queue fills.
// ----------------------------------------------------------------------------
module daisy_chain_led_driver_serializer #(
   parameter int MAX_DEVICES = dcls_pkg::DCLS_MAX_DEVICES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  dcls_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dcls_pkg::rsp_type rsp_data
);
   import dcls_pkg::*;

   job_type front_job;
   job_type head_job;
   logic    queue_full;
   logic    queue_empty;
   logic    queue_pop;

   assign req_stall = queue_full;

   // Classify request beats
   dcls_front #(
      .MAX_DEVICES(MAX_DEVICES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .job              (front_job)
   );

   // Buffer jobs
   dcls_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_valid),
      .push_job (front_job),
      .full     (queue_full),
      .pop      (queue_pop),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   // Shift bits out
   dcls_back #(
      .MAX_DEVICES(MAX_DEVICES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_job    (head_job),
      .pop         (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

[src/dcls_front.sv]
// ----------------------------------------------------------------------------
// dcls_front: input stage of the serializer
// Holds the chain length register and turns each request beat into a job
// with the frame built and the chain length and target clamped.
// ----------------------------------------------------------------------------
module dcls_front #(
   parameter int MAX_DEVICES = dcls_pkg::DCLS_MAX_DEVICES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_write_data,
   input  dcls_pkg::req_type req_data,
   output dcls_pkg::job_type job
);
   import dcls_pkg::*;

   localparam logic [2:0] MAX_LEN = 3'(MAX_DEVICES);

   logic [2:0] csr_length_ff;
   logic [2:0] csr_length_in;
   logic [2:0] length;
   logic [2:0] target;

   // Take a register write
   always_comb begin
      csr_length_in = csr_length_ff;
      if (csr_write_enable) begin
         csr_length_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_length_ff <= CSR_LENGTH_RESET;
      end else begin
         csr_length_ff <= csr_length_in;
      end
   end

   // Clamp chain length to 1..MAX_DEVICES
   always_comb begin
      length = csr_length_ff;
      if (csr_length_ff == 3'd0) begin
         length = 3'd1;
      end else if (csr_length_ff > MAX_LEN) begin
         length = MAX_LEN;
      end
   end

   // Clamp target to 1..length
   always_comb begin
      target = req_data.target_device;
      if (req_data.target_device == 3'd0) begin
         target = 3'd1;
      end else if (req_data.target_device > length) begin
         target = length;
      end
   end

   // Build the job
   always_comb begin
      job.frame  = {req_data.register_address, req_data.data_byte};
      job.kind   = req_data.kind;
      job.target = target;
      job.length = length;
   end

endmodule

[src/dcls_queue.sv]
// ----------------------------------------------------------------------------
// dcls_queue: short job queue between front and back
// Small register queue so the input side keeps taking beats while the
// serializer is still shifting an earlier write.
// ----------------------------------------------------------------------------
module dcls_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dcls_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output dcls_pkg::job_type head_job
);
   import dcls_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_push_only_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      full |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with full count");

endmodule

[src/dcls_back.sv]
// ----------------------------------------------------------------------------
// dcls_back: bit serializer
// Shifts each job out one bit per cycle unless a stalled beat is held, farthest
// chip first, MSB first, through an output register; flags each write's last bit.
// ----------------------------------------------------------------------------
module dcls_back #(
   parameter int MAX_DEVICES = dcls_pkg::DCLS_MAX_DEVICES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  dcls_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dcls_pkg::rsp_type rsp_data
);
   import dcls_pkg::*;

   localparam logic [BIT_IDX_W-1:0] LAST_IDX = BIT_IDX_W'(FRAME_BITS - 1);

   job_type              job_ff;
   job_type              job_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic [2:0]           chip_ff;
   logic [2:0]           chip_in;
   logic [BIT_IDX_W-1:0] bit_ff;
   logic [BIT_IDX_W-1:0] bit_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 advance;
   logic                 last;
   logic                 finish;
   logic [FRAME_BITS-1:0] word;

   assign advance = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign last    = (chip_ff == 3'd1) && (bit_ff == LAST_IDX);
   assign finish  = advance && last;
   assign pop     = !queue_empty && (!busy_ff || finish);

   // Pick the frame for the current chip
   always_comb begin
      word = job_ff.frame;
      if (job_ff.kind == KIND_TARGETED && chip_ff != job_ff.target) begin
         word = NOOP_FRAME;
      end
   end

   // Load the next job or step through bits and chips
   always_comb begin
      job_in  = job_ff;
      busy_in = busy_ff;
      chip_in = chip_ff;
      bit_in  = bit_ff;
      if (pop) begin
         job_in  = head_job;
         busy_in = 1'b1;
         chip_in = head_job.length;
         bit_in  = '0;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (advance) begin
         bit_in = bit_ff + 1'b1;
         if (bit_ff == LAST_IDX) begin
            chip_in = chip_ff - 3'd1;
         end
      end
   end

   // Hold the output beat until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in       = 1'b1;
         rsp_in.serial_bit  = word[LAST_IDX - bit_ff];
         rsp_in.last_bit    = last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      chip_ff <= chip_in;
      bit_ff  <= bit_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_chip_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (chip_ff != 3'd0 && chip_ff <= 3'(MAX_DEVICES)))
      else $error("chip index out of range while busy");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (finish && !pop) |=> !busy_ff)
      else $error("serializer still busy after final bit");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      (advance && !last) |=> (busy_ff && rsp_valid_ff))
      else $error("serializer dropped a job mid-write");

endmodule
